// File: hdl/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lpht_pkg
// shared types and constants for the linear probing hash table
// ---------------------------------------------------------------------------
package lpht_pkg;

  localparam int MaxSlots  = 1024;
  localparam int SlotAw    = $clog2(MaxSlots);
  localparam int CntW      = SlotAw + 1;
  localparam int KeyW      = 31;
  localparam int HandleW   = 16;
  localparam int FuncW     = 2;
  localparam int CfgW      = 11;
  localparam int EpochW    = 8;
  // entry word: epoch, key, handle
  localparam int EntryW    = EpochW + KeyW + HandleW;
  localparam int QDepth    = 2;

  localparam logic [FuncW-1:0] FUNC_FIND   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] row_handle;
    logic               overwrite;
  } lpht_req_t;

  typedef struct packed {
    logic               found;
    logic [HandleW-1:0] found_handle;
    logic               table_full;
  } lpht_rsp_t;

endpackage : lpht_pkg
`default_nettype wire

// File: hdl/lpht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lpht_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule : lpht_ram
`default_nettype wire

// File: hdl/lpht_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lpht_front
// accepts transactions into a short queue for the probe engine
// ---------------------------------------------------------------------------
module lpht_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lpht_pkg::lpht_req_t             in_req,
  output logic                                 q_valid,
  input  wire logic                            q_pop,
  output lpht_pkg::lpht_req_t                  q_req
);
  import lpht_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  lpht_req_t        buf_r [QDepth];
  logic [PtrW-1:0]  wp_r, rp_r;
  logic [PtrW:0]    cnt_r;
  logic             push;

  assign in_stall = (cnt_r == (PtrW+1)'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_req;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(QDepth)) else $error("queue overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (PtrW+1)'(QDepth)) |-> in_stall) else $error("full queue not stalling");

endmodule : lpht_front
`default_nettype wire

// File: hdl/lpht_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lpht_back
// probe engine: home slot by subtract loop, linear walk over the ram
// ---------------------------------------------------------------------------
module lpht_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [lpht_pkg::CfgW-1:0]  slots_cfg,
  input  wire logic                       q_valid,
  output logic                            q_pop,
  input  wire lpht_pkg::lpht_req_t        q_req,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output lpht_pkg::lpht_rsp_t             out_rsp
);
  import lpht_pkg::*;

  // divisor register wide enough for the slot count shifted past every key bit
  localparam int DshW = KeyW + SlotAw;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_READ, ST_CHECK, ST_WIPE, ST_OUT
  } state_t;

  state_t              state_r;
  lpht_req_t           req_r;
  logic [KeyW-1:0]     rem_r;
  logic [DshW-1:0]     dsh_r;
  logic [SlotAw-1:0]   slot_r;
  logic [CntW-1:0]     count_r;
  logic [CntW-1:0]     n_r;
  logic [EpochW-1:0]   epoch_r;
  logic [SlotAw-1:0]   wipe_r;
  logic                wiping_r;
  lpht_rsp_t           rsp_r;

  logic                ram_we;
  logic [SlotAw-1:0]   ram_addr;
  logic [EntryW-1:0]   ram_wdata, ram_rdata;
  logic [CntW-1:0]     n_eff;
  logic [EpochW-1:0]   e_rd;
  logic [KeyW-1:0]     k_rd;
  logic [HandleW-1:0]  h_rd;
  logic                slot_live;
  logic [SlotAw:0]     slot_inc;
  logic [DshW-1:0]     rem_x;
  logic                rem_ge;

  // epoch 0 marks empty; a clear bumps the epoch, a wrap sweeps the ram
  always_comb begin
    if (slots_cfg == '0) begin
      n_eff = CntW'(1);
    end else if (CntW'(slots_cfg) > CntW'(MaxSlots)) begin
      n_eff = CntW'(MaxSlots);
    end else begin
      n_eff = CntW'(slots_cfg);
    end
  end

  assign {e_rd, k_rd, h_rd} = ram_rdata;
  assign slot_live = (e_rd == epoch_r) && (epoch_r != '0);
  assign slot_inc  = {1'b0, slot_r} + 1'b1;
  assign rem_x     = DshW'(rem_r);
  assign rem_ge    = (rem_x >= dsh_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_r;
    ram_wdata = {epoch_r, req_r.key, req_r.row_handle};
    if (state_r == ST_WIPE) begin
      ram_we    = 1'b1;
      ram_addr  = wipe_r;
      ram_wdata = '0;
    end else if (state_r == ST_CHECK && count_r != n_r && req_r.func == FUNC_INSERT) begin
      if (!slot_live) begin
        ram_we = 1'b1;
      end else if (k_rd == req_r.key && req_r.overwrite) begin
        ram_we    = 1'b1;
        ram_wdata = {epoch_r, k_rd, req_r.row_handle};
      end
    end
  end

  lpht_ram #(.Width(EntryW), .Depth(MaxSlots)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign out_valid = (state_r == ST_OUT);
  assign out_rsp   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_WIPE;
      epoch_r  <= EpochW'(1);
      wipe_r   <= '0;
      wiping_r <= 1'b1;
      rsp_r    <= '0;
      req_r    <= '0;
      rem_r    <= '0;
      dsh_r    <= '0;
      slot_r   <= '0;
      count_r  <= '0;
      n_r      <= CntW'(1);
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            req_r <= q_req;
            rsp_r <= '0;
            if (q_req.func == FUNC_CLEAR) begin
              if (epoch_r == '1) begin
                state_r  <= ST_WIPE;
                wipe_r   <= '0;
                wiping_r <= 1'b0;
              end else begin
                epoch_r <= epoch_r + 1'b1;
                state_r <= ST_OUT;
              end
            end else if (q_req.func == FUNC_FIND || q_req.func == FUNC_INSERT) begin
              n_r   <= n_eff;
              rem_r <= q_req.key;
              dsh_r <= DshW'(n_eff) << (KeyW - 1);
              state_r <= ST_MOD;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_MOD: begin
          // restoring remainder, one shifted divisor a cycle
          if (rem_ge) begin
            rem_r <= KeyW'(rem_x - dsh_r);
          end
          dsh_r <= dsh_r >> 1;
          if (dsh_r == DshW'(n_r)) begin
            slot_r  <= rem_ge ? SlotAw'(rem_x - dsh_r) : SlotAw'(rem_r);
            count_r <= '0;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          if (count_r == n_r) begin
            rsp_r   <= '{found: 1'b0, found_handle: '0, table_full: 1'b1};
            state_r <= ST_OUT;
          end else if (!slot_live) begin
            state_r <= ST_OUT;
          end else if (k_rd == req_r.key) begin
            rsp_r   <= '{found: 1'b1, found_handle: h_rd, table_full: 1'b0};
            state_r <= ST_OUT;
          end else begin
            count_r <= count_r + 1'b1;
            slot_r  <= (CntW'(slot_inc) >= n_r) ? '0 : slot_inc[SlotAw-1:0];
            state_r <= ST_READ;
          end
        end
        ST_WIPE: begin
          wipe_r <= wipe_r + 1'b1;
          if (wipe_r == SlotAw'(MaxSlots - 1)) begin
            epoch_r <= EpochW'(1);
            state_r <= wiping_r ? ST_IDLE : ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != ST_IDLE)) else $error("pop without leaving idle");
  a_epoch_nz: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0) else $error("epoch zero");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_rsp)) else $error("result moved");
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_rsp.found && out_rsp.table_full)) else $error("found and full");

endmodule : lpht_back
`default_nettype wire

// File: hdl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing hash table with linear probing over a single port ram
// ---------------------------------------------------------------------------
// transactions enter on in_* (valid/stall) into a two deep queue, so the
// sender is only held once that queue is full. the probe engine takes one
// transaction at a time: the key modulo slot count (one remainder bit a
// cycle), then a read and a check step per probed slot on the ram port,
// then one result on out_*. a result waits in its register while out_stall
// is high; the engine then holds, the queue keeps taking transactions until
// it is full. clear bumps an epoch tag, except every 255th clear, which
// sweeps the whole ram. after reset the same sweep runs before the first
// transaction leaves the queue. cfg_table_slots may be written at any time
// the block is idle; 0 acts as 1, above 1024 as 1024.
// ---------------------------------------------------------------------------
module linear_probe_hash_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [lpht_pkg::CfgW-1:0]     cfg_table_slots,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lpht_pkg::FuncW-1:0]    in_func,
  input  wire logic [lpht_pkg::KeyW-1:0]     in_key,
  input  wire logic [lpht_pkg::HandleW-1:0]  in_row_handle,
  input  wire logic                          in_overwrite,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [lpht_pkg::HandleW-1:0]       out_found_handle,
  output logic                               out_table_full
);
  import lpht_pkg::*;

  logic [CfgW-1:0] slots_r;
  lpht_req_t       in_req, q_req;
  lpht_rsp_t       rsp;
  logic            q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= CfgW'(MaxSlots);
    end else if (cfg_we) begin
      slots_r <= cfg_table_slots;
    end
  end

  assign in_req = '{func: in_func, key: in_key, row_handle: in_row_handle,
                    overwrite: in_overwrite};

  lpht_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_req    (q_req)
  );

  lpht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .slots_cfg (slots_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (rsp)
  );

  assign out_found        = rsp.found;
  assign out_found_handle = rsp.found_handle;
  assign out_table_full   = rsp.table_full;

endmodule : linear_probe_hash_table
`default_nettype wire
